[rtl/stve_pkg.sv]
// ---------------------------------------------------------------------------
// stve_pkg: shared types and constants of the vendor string extractor
// Result codes, configuration register indexes, header constants and the
// records passed between the front parser and the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

package stve_pkg;

  // result kinds
  localparam logic [2:0] K_CHAR          = 3'd0;
  localparam logic [2:0] K_NOT_SPECIFIED = 3'd1;
  localparam logic [2:0] K_END_TYPE      = 3'd2;
  localparam logic [2:0] K_SHORT_HEADER  = 3'd3;
  localparam logic [2:0] K_OVERRUN       = 3'd4;
  localparam logic [2:0] K_LIMIT         = 3'd5;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LENGTH    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRUCTURE_LIMIT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_AT_FIRST   = 8'd2;

  // structure table constants
  localparam logic [7:0] END_TYPE             = 8'd127;
  localparam logic [7:0] BIOS_INFO_MIN_LENGTH = 8'd18;
  localparam logic [7:0] VENDOR_OFFSET        = 8'h04;
  localparam logic [7:0] HEADER_BYTES         = 8'd4;

  // default depth of the result queue
  localparam int STVE_QUEUE_DEPTH = 4;

  // configuration register set
  typedef struct packed {
    logic [31:0] table_length;
    logic [15:0] structure_limit;
    logic        stop_at_first_vendor;
  } cfg_t;

  // one result record
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] vendor_char;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[rtl/stve_parser.sv]
// ---------------------------------------------------------------------------
// stve_parser: front part of the extractor
// Accepts table bytes, walks the structure headers, formatted areas and
// string sets, and pushes at most one result record per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module stve_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   take,
  input  wire  [7:0]            table_byte,
  input  wire                   restart,
  input  stve_pkg::cfg_t        cfg,
  output logic                  push,
  output stve_pkg::result_t     res
);
  import stve_pkg::*;

  // parse phases
  localparam logic [1:0] PH_HEADER    = 2'd0;
  localparam logic [1:0] PH_FORMATTED = 2'd1;
  localparam logic [1:0] PH_STR_FIRST = 2'd2;
  localparam logic [1:0] PH_STRINGS   = 2'd3;

  logic [31:0] byte_position, byte_position_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic [7:0]  bytes_into_structure, bytes_into_structure_next;
  logic [7:0]  structure_type, structure_type_next;
  logic [7:0]  formatted_length, formatted_length_next;
  logic [7:0]  wanted_string_number, wanted_string_number_next;
  logic [7:0]  current_string_number, current_string_number_next;
  logic [15:0] structures_seen, structures_seen_next;
  logic        previous_was_null, previous_was_null_next;
  logic        walk_finished, walk_finished_next;

  // state as seen by this byte, after an optional restart
  logic [31:0] c_pos;
  logic [1:0]  c_phase;
  logic [7:0]  c_bis;
  logic [7:0]  c_type;
  logic [7:0]  c_flen;
  logic [7:0]  c_wanted;
  logic [7:0]  c_cur;
  logic [15:0] c_seen;
  logic        c_prev;
  logic        c_fin;

  logic [7:0]  bis_inc;
  logic        near_end;
  logic        past_end;
  logic        match;

  always_comb begin
    c_pos    = restart ? '0 : byte_position;
    c_phase  = restart ? PH_HEADER : parse_phase;
    c_bis    = restart ? '0 : bytes_into_structure;
    c_type   = restart ? '0 : structure_type;
    c_flen   = restart ? '0 : formatted_length;
    c_wanted = restart ? '0 : wanted_string_number;
    c_cur    = restart ? '0 : current_string_number;
    c_seen   = restart ? '0 : structures_seen;
    c_prev   = restart ? 1'b0 : previous_was_null;
    c_fin    = restart ? 1'b0 : walk_finished;
  end

  assign bis_inc  = c_bis + 8'd1;
  assign near_end = ({1'b0, c_pos} + 33'd4) >= {1'b0, cfg.table_length};
  assign past_end = c_pos >= cfg.table_length;
  assign match    = (c_wanted != 8'd0) && (c_cur == c_wanted);

  // next-state and result logic
  always_comb begin
    byte_position_next         = byte_position;
    parse_phase_next           = parse_phase;
    bytes_into_structure_next  = bytes_into_structure;
    structure_type_next        = structure_type;
    formatted_length_next      = formatted_length;
    wanted_string_number_next  = wanted_string_number;
    current_string_number_next = current_string_number;
    structures_seen_next       = structures_seen;
    previous_was_null_next     = previous_was_null;
    walk_finished_next         = walk_finished;
    push                       = 1'b0;
    res                        = '0;

    if (take) begin
      byte_position_next         = c_pos;
      parse_phase_next           = c_phase;
      bytes_into_structure_next  = c_bis;
      structure_type_next        = c_type;
      formatted_length_next      = c_flen;
      wanted_string_number_next  = c_wanted;
      current_string_number_next = c_cur;
      structures_seen_next       = c_seen;
      previous_was_null_next     = c_prev;
      walk_finished_next         = c_fin;

      if (!c_fin) begin
        if (c_pos != '1) begin
          byte_position_next = c_pos + 32'd1;
        end

        if (c_phase == PH_HEADER) begin
          if (c_bis == 8'd0) begin
            // structure start: limit and remaining-length check
            if ((c_seen >= cfg.structure_limit) || near_end) begin
              walk_finished_next = 1'b1;
              push = 1'b1;
              res = '{kind: K_LIMIT, vendor_char: 8'd0, last: 1'b1};
            end else begin
              structures_seen_next      = c_seen + 16'd1;
              structure_type_next       = table_byte;
              wanted_string_number_next = 8'd0;
              bytes_into_structure_next = 8'd1;
            end
          end else if (c_bis == 8'd1) begin
            // length byte
            formatted_length_next     = table_byte;
            bytes_into_structure_next = 8'd2;
            if (table_byte < HEADER_BYTES) begin
              walk_finished_next = 1'b1;
              push = 1'b1;
              res = '{kind: K_SHORT_HEADER, vendor_char: 8'd0, last: 1'b1};
            end else if (c_type == END_TYPE) begin
              walk_finished_next = 1'b1;
              push = 1'b1;
              res = '{kind: K_END_TYPE, vendor_char: 8'd0, last: 1'b1};
            end
          end else begin
            // handle bytes
            bytes_into_structure_next = bis_inc;
            if (bis_inc >= HEADER_BYTES) begin
              if (c_flen <= HEADER_BYTES) begin
                parse_phase_next           = PH_STR_FIRST;
                current_string_number_next = 8'd1;
                previous_was_null_next     = 1'b0;
              end else begin
                parse_phase_next = PH_FORMATTED;
              end
            end
          end
        end else if (past_end) begin
          walk_finished_next = 1'b1;
          push = 1'b1;
          res = '{kind: K_OVERRUN, vendor_char: 8'd0, last: 1'b1};
        end else begin
          unique case (c_phase)
            PH_FORMATTED: begin
              bytes_into_structure_next = bis_inc;
              if (bis_inc >= c_flen) begin
                parse_phase_next           = PH_STR_FIRST;
                current_string_number_next = 8'd1;
                previous_was_null_next     = 1'b0;
              end
              // vendor string index of a BIOS-information structure
              if ((c_bis == VENDOR_OFFSET) && (c_type == 8'd0) &&
                  (c_flen >= BIOS_INFO_MIN_LENGTH)) begin
                if (table_byte == 8'd0) begin
                  wanted_string_number_next = 8'd0;
                  if (cfg.stop_at_first_vendor) walk_finished_next = 1'b1;
                  push = 1'b1;
                  res = '{kind: K_NOT_SPECIFIED, vendor_char: 8'd0, last: 1'b1};
                end else begin
                  wanted_string_number_next = table_byte;
                end
              end
            end
            PH_STR_FIRST: begin
              parse_phase_next = PH_STRINGS;
              if (table_byte == 8'd0) begin
                previous_was_null_next = 1'b1;
              end else begin
                previous_was_null_next = 1'b0;
                if (c_wanted == 8'd1) begin
                  push = 1'b1;
                  res = '{kind: K_CHAR, vendor_char: table_byte, last: 1'b0};
                end
              end
            end
            PH_STRINGS: begin
              if ((table_byte == 8'd0) && c_prev) begin
                // double null ends the string set
                parse_phase_next          = PH_HEADER;
                bytes_into_structure_next = 8'd0;
                if (c_wanted != 8'd0) begin
                  wanted_string_number_next = 8'd0;
                  if (cfg.stop_at_first_vendor) walk_finished_next = 1'b1;
                  push = 1'b1;
                  res = '{kind: K_NOT_SPECIFIED, vendor_char: 8'd0, last: 1'b1};
                end
              end else if (table_byte == 8'd0) begin
                // end of one string
                previous_was_null_next = 1'b1;
                if (c_cur != 8'hFF) current_string_number_next = c_cur + 8'd1;
                if (match) begin
                  wanted_string_number_next = 8'd0;
                  if (cfg.stop_at_first_vendor) walk_finished_next = 1'b1;
                  push = 1'b1;
                  res = '{kind: K_CHAR, vendor_char: 8'd0, last: 1'b1};
                end
              end else begin
                previous_was_null_next = 1'b0;
                if (match) begin
                  push = 1'b1;
                  res = '{kind: K_CHAR, vendor_char: table_byte, last: 1'b0};
                end
              end
            end
            default: begin
              parse_phase_next          = PH_HEADER;
              bytes_into_structure_next = 8'd0;
            end
          endcase
        end
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position         <= '0;
      parse_phase           <= PH_HEADER;
      bytes_into_structure  <= '0;
      structure_type        <= '0;
      formatted_length      <= '0;
      wanted_string_number  <= '0;
      current_string_number <= '0;
      structures_seen       <= '0;
      previous_was_null     <= 1'b0;
      walk_finished         <= 1'b0;
    end else begin
      byte_position         <= byte_position_next;
      parse_phase           <= parse_phase_next;
      bytes_into_structure  <= bytes_into_structure_next;
      structure_type        <= structure_type_next;
      formatted_length      <= formatted_length_next;
      wanted_string_number  <= wanted_string_number_next;
      current_string_number <= current_string_number_next;
      structures_seen       <= structures_seen_next;
      previous_was_null     <= previous_was_null_next;
      walk_finished         <= walk_finished_next;
    end
  end

endmodule

`default_nettype wire

[rtl/stve_queue.sv]
// ---------------------------------------------------------------------------
// stve_queue: back part of the extractor
// Small flip-flop queue of result records that decouples the parser from
// the output handshake and presents the oldest record on the output.
// ---------------------------------------------------------------------------
`default_nettype none

module stve_queue #(
  parameter int DEPTH = stve_pkg::STVE_QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  stve_pkg::result_t     push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire                   out_ready,
  output stve_pkg::result_t     out_data
);
  import stve_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic             do_push;

  assign full      = (count == FULL_CNT);
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign do_push   = push && !full;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/smbios_table_vendor_extractor.sv]
// ---------------------------------------------------------------------------
// smbios_table_vendor_extractor: structure table walker, vendor string out
// A result enters the result queue in the cycle after the byte that causes it.
// One table byte is taken per cycle while in_ready is high; in_ready falls only while the
// result queue is full, which the output side sets by taking results.
// Reset clears the parse state, empties the queue and returns the
// registers to table_length 0, structure_limit 65535, stop flag 0.
// ---------------------------------------------------------------------------
`default_nettype none

module smbios_table_vendor_extractor #(
  parameter int QUEUE_DEPTH = stve_pkg::STVE_QUEUE_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst,
  // table byte requests
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [7:0]                        table_byte,
  input  wire                               restart,
  // result requests
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [2:0]                        kind,
  output logic [7:0]                        vendor_char,
  output logic                              last,
  // configuration writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [stve_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [stve_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stve_pkg::*;

  cfg_t    cfg;
  logic    take;
  logic    push;
  logic    full;
  result_t push_data;
  result_t out_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign take      = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_length         <= '0;
      cfg.structure_limit      <= 16'hFFFF;
      cfg.stop_at_first_vendor <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TABLE_LENGTH:    cfg.table_length         <= cfg_data[31:0];
        CFG_STRUCTURE_LIMIT: cfg.structure_limit      <= cfg_data[15:0];
        CFG_STOP_AT_FIRST:   cfg.stop_at_first_vendor <= cfg_data[0];
        default: ;
      endcase
    end
  end

  stve_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .table_byte (table_byte),
    .restart    (restart),
    .cfg        (cfg),
    .push       (push),
    .res        (push_data)
  );

  stve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind        = out_data.kind;
  assign vendor_char = out_data.vendor_char;
  assign last        = out_data.last;

endmodule

`default_nettype wire
